// ----- rtl/core/toeq_pkg.sv -----
// Package for the timestamp ordered event queue: sizes, command and status
// codes, entry and control types shared by the cells and the top level.
// No dependencies.
package toeq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TIME_BITS   = 24;
    localparam int PID_BITS    = 8;
    localparam int STATE_BITS  = 2;
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int NEXT_BITS   = TIME_BITS + 1;

    // Command codes carried on the input channel.
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_REMOVE = 2'd3
    } t_cmd;

    // Status codes carried on the result channel.
    typedef enum logic [1:0] {
        STS_OK   = 2'd0,
        STS_MISS = 2'd1,
        STS_FULL = 2'd2
    } t_status;

    // Sequencer states.
    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } t_fsm;

    // One queued event.
    typedef struct packed {
        logic [TIME_BITS-1:0]  time_stamp;
        logic [PID_BITS-1:0]   pid;
        logic [STATE_BITS-1:0] from_state;
        logic [STATE_BITS-1:0] to_state;
    } t_entry;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic   ins_en;
        logic   del_en;
        logic   pop;
        t_entry key;
    } t_cell_ctrl;

endpackage

// ----- rtl/core/toeq_ifs.sv -----
// Valid/ready channel interfaces for the event queue command and result.
// Depends on toeq_pkg for field widths.
interface toeq_cmd_if
    import toeq_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [1:0]            command;
    logic [TIME_BITS-1:0]  event_time;
    logic [PID_BITS-1:0]   process_id;
    logic [STATE_BITS-1:0] from_state;
    logic [STATE_BITS-1:0] to_state;

    modport source (output valid, command, event_time, process_id, from_state, to_state,
                    input ready);
    modport sink   (input valid, command, event_time, process_id, from_state, to_state,
                    output ready);
endinterface

interface toeq_rsp_if
    import toeq_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic [TIME_BITS-1:0]  entry_time;
    logic [PID_BITS-1:0]   entry_process;
    logic [STATE_BITS-1:0] entry_from_state;
    logic [STATE_BITS-1:0] entry_to_state;
    logic [NEXT_BITS-1:0]  next_time;
    logic [CNT_BITS-1:0]   entry_count;

    modport source (output valid, status, entry_time, entry_process, entry_from_state,
                    entry_to_state, next_time, entry_count, input ready);
    modport sink   (input valid, status, entry_time, entry_process, entry_from_state,
                    entry_to_state, next_time, entry_count, output ready);
endinterface

// ----- rtl/core/toeq_cell.sv -----
// One slot of the sorted event chain: holds an entry, compares it against the
// broadcast key and shifts toward either neighbor. Depends on toeq_pkg.
module toeq_cell
    import toeq_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_live,
    input  logic       i_left_le,
    input  t_entry     i_left,
    input  t_entry     i_right,
    input  logic       i_hit,
    input  t_entry     i_sel,
    output logic       o_le,
    output logic       o_hit,
    output t_entry     o_sel,
    output t_entry     o_data,
    output t_entry     o_next
);

    t_entry r_data;
    t_entry n_data;
    logic   match;

    // Compare the stored entry against the key.
    assign o_le  = i_live && (r_data.time_stamp <= i_ctrl.key.time_stamp);
    assign match = i_live && (i_ctrl.pop || (r_data.pid == i_ctrl.key.pid));

    // First-match chain: the first matching cell passes its entry down the row.
    assign o_hit = i_hit || match;
    assign o_sel = i_hit ? i_sel : (match ? r_data : '0);

    // Insert shifts right past the key position; delete closes the gap from the right.
    always_comb begin
        n_data = r_data;
        if (i_ctrl.ins_en && !o_le) begin
            n_data = i_left_le ? i_ctrl.key : i_left;
        end else if (i_ctrl.del_en && (i_hit || match)) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_next = n_data;

endmodule

// ----- rtl/core/timestamp_ordered_event_queue_unit.sv -----
// Top level of the timestamp ordered event queue: command sequencer, the row
// of toeq_cell slots and the result register. Depends on toeq_pkg, toeq_ifs.
//
// Usage:
//   Commands arrive on i_cmd (insert, pop, find, remove) and each produces
//   exactly one result transfer on o_rsp carrying the status, the entry
//   popped, found or removed, the front timestamp after the command (all
//   ones when the queue is empty) and the entry count.
//   The queue is a row of QUEUE_DEPTH slots kept in timestamp order. Every
//   slot compares its entry against the command key in parallel; an insert
//   shifts the tail right by one slot, a pop or remove shifts it left.
//   Timing: a command is captured on its transfer and executed in the
//   execute state, which writes the result register once the output
//   register is free. i_cmd.ready is low in the execute state, so a new
//   command is taken only after the previous one has been executed.
//   If the receiver stalls, the finished result holds in the output register
//   and the next command is still captured; it then waits in the execute
//   cycle until the output register frees up, and i_cmd.ready stays low.
//   Reset clears the sequencer, the entry count and the result valid; slot
//   contents are not reset, the count alone tells which slots hold entries.
module timestamp_ordered_event_queue_unit
    import toeq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    toeq_cmd_if.sink   i_cmd,
    toeq_rsp_if.source o_rsp
);

    t_fsm                 r_state;
    t_fsm                 n_state;
    t_cmd                 r_cmd;
    t_entry               r_key;
    logic [CNT_BITS-1:0]  r_count;
    logic [CNT_BITS-1:0]  n_count;

    logic                 r_out_valid;
    t_status              r_status;
    t_entry               r_result;
    logic [NEXT_BITS-1:0] r_next_time;
    logic [CNT_BITS-1:0]  r_out_count;

    logic                 accept;
    logic                 commit;
    logic                 full;
    logic                 found;
    t_status              status;
    t_entry               result;
    logic [NEXT_BITS-1:0] next_time;
    t_cell_ctrl           ctrl;

    logic   live   [QUEUE_DEPTH];
    logic   le     [QUEUE_DEPTH];
    logic   hit    [QUEUE_DEPTH];
    t_entry sel    [QUEUE_DEPTH];
    t_entry data   [QUEUE_DEPTH];
    t_entry next_d [QUEUE_DEPTH];

    // Input transfer and execute handshake.
    assign i_cmd.ready = (r_state == FSM_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign commit      = (r_state == FSM_EXEC) && (!r_out_valid || o_rsp.ready);
    assign full        = (r_count == CNT_BITS'(QUEUE_DEPTH));

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FSM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            FSM_IDLE: begin
                if (accept) begin
                    n_state = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                if (commit) begin
                    n_state = FSM_IDLE;
                end
            end
            default: n_state = FSM_IDLE;
        endcase
    end

    // Capture the command on its transfer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd            <= t_cmd'(i_cmd.command);
            r_key.time_stamp <= i_cmd.event_time;
            r_key.pid        <= i_cmd.process_id;
            r_key.from_state <= i_cmd.from_state;
            r_key.to_state   <= i_cmd.to_state;
        end
    end

    // Broadcast control to the slot row, gated by the execute cycle.
    always_comb begin
        ctrl.key    = r_key;
        ctrl.pop    = (r_cmd == CMD_POP);
        ctrl.ins_en = commit && (r_cmd == CMD_INSERT) && !full;
        ctrl.del_en = commit && ((r_cmd == CMD_POP) || (r_cmd == CMD_REMOVE));
    end

    // Row of slots; slot i holds an entry when i is below the count.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        assign live[g] = (CNT_BITS'(g) < r_count);

        if (g == 0) begin : g_head
            toeq_cell u_cell (
                .i_clk     (i_clk),
                .i_ctrl    (ctrl),
                .i_live    (live[g]),
                .i_left_le (1'b1),
                .i_left    (r_key),
                .i_right   (data[g+1]),
                .i_hit     (1'b0),
                .i_sel     ('0),
                .o_le      (le[g]),
                .o_hit     (hit[g]),
                .o_sel     (sel[g]),
                .o_data    (data[g]),
                .o_next    (next_d[g])
            );
        end else if (g == QUEUE_DEPTH - 1) begin : g_tail
            toeq_cell u_cell (
                .i_clk     (i_clk),
                .i_ctrl    (ctrl),
                .i_live    (live[g]),
                .i_left_le (le[g-1]),
                .i_left    (data[g-1]),
                .i_right   (data[g]),
                .i_hit     (hit[g-1]),
                .i_sel     (sel[g-1]),
                .o_le      (le[g]),
                .o_hit     (hit[g]),
                .o_sel     (sel[g]),
                .o_data    (data[g]),
                .o_next    (next_d[g])
            );
        end else begin : g_mid
            toeq_cell u_cell (
                .i_clk     (i_clk),
                .i_ctrl    (ctrl),
                .i_live    (live[g]),
                .i_left_le (le[g-1]),
                .i_left    (data[g-1]),
                .i_right   (data[g+1]),
                .i_hit     (hit[g-1]),
                .i_sel     (sel[g-1]),
                .o_le      (le[g]),
                .o_hit     (hit[g]),
                .o_sel     (sel[g]),
                .o_data    (data[g]),
                .o_next    (next_d[g])
            );
        end
    end

    assign found  = hit[QUEUE_DEPTH-1];
    assign result = sel[QUEUE_DEPTH-1];

    // Status, new count and front timestamp for this command.
    always_comb begin
        status  = STS_OK;
        n_count = r_count;
        case (r_cmd)
            CMD_INSERT: begin
                if (full) begin
                    status = STS_FULL;
                end else begin
                    n_count = r_count + CNT_BITS'(1);
                end
            end
            CMD_POP, CMD_REMOVE: begin
                if (!found) begin
                    status = STS_MISS;
                end else begin
                    n_count = r_count - CNT_BITS'(1);
                end
            end
            CMD_FIND: begin
                if (!found) begin
                    status = STS_MISS;
                end
            end
            default: status = STS_MISS;
        endcase
        if (n_count == '0) begin
            next_time = '1;
        end else begin
            next_time = {1'b0, next_d[0].time_stamp};
        end
    end

    // Entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (commit) begin
            r_count <= n_count;
        end
    end

    // Result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload; insert results carry no entry.
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_status    <= status;
            r_result    <= (r_cmd == CMD_INSERT) ? t_entry'('0) : result;
            r_next_time <= next_time;
            r_out_count <= n_count;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.status           = r_status;
    assign o_rsp.entry_time       = r_result.time_stamp;
    assign o_rsp.entry_process    = r_result.pid;
    assign o_rsp.entry_from_state = r_result.from_state;
    assign o_rsp.entry_to_state   = r_result.to_state;
    assign o_rsp.next_time        = r_next_time;
    assign o_rsp.entry_count      = r_out_count;

endmodule
